[rtl/rgbc_pkg.sv]
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types, constants and helpers of the normalised RGB 3x3 convolution.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int ROW_W = 29;
    localparam logic [ROW_W-1:0] ROW_SAT = 29'h1000_0000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_TOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K_MID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K_BOT = 3'd4;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [23:0] RST_K_TOP  = 24'h000000;
    localparam logic [23:0] RST_K_MID  = 24'h000100;
    localparam logic [23:0] RST_K_BOT  = 24'h000000;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int ACC_W = 21;
    localparam int SUM_W = 12;
    localparam int DVS_W = 11;
    localparam int Q_W   = 19;
    localparam int REM_W = 12;
    localparam logic [4:0] DIV_LAST = 5'd18;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_out_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_MUL,
        S_CMP,
        S_MAC,
        S_DIV_INIT,
        S_DIV,
        S_PUT
    } t_state;

    typedef struct packed {
        logic start;
        logic read;
        logic shift;
        logic mul;
        logic mac_init;
        logic mac_step;
        logic div_init;
        logic div_step;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic emit;
        logic mac_last;
        logic div_last;
        logic out_full;
    } t_stat;

    function automatic logic signed [7:0] coef(input logic [23:0] row, input logic [1:0] idx);
        logic signed [7:0] k;
        unique case (idx)
            2'd0:    k = signed'(row[7:0]);
            2'd1:    k = signed'(row[15:8]);
            2'd2:    k = signed'(row[23:16]);
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

[rtl/rgbc_ctrl.sv]
// ----------------------------------------------------------------------------
// rgbc_ctrl
// Sequencer: steps one request through window update, timing check,
// multiply-accumulate, division and result hand-off.
// ----------------------------------------------------------------------------
module rgbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rgbc_pkg::t_stat i_stat,
    output rgbc_pkg::t_cmd  o_cmd
);
    import rgbc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE:   n_state = i_stat.skip ? S_IDLE : S_SHIFT;
            S_SHIFT:    n_state = S_MUL;
            S_MUL:      n_state = S_CMP;
            S_CMP:      n_state = i_stat.emit ? S_MAC : S_IDLE;
            S_MAC:      if (i_stat.mac_last) n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV:      if (i_stat.div_last) n_state = S_PUT;
            S_PUT:      if (!i_stat.out_full) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE:     o_cmd.start = i_in_valid;
            S_DECIDE:   o_cmd.read = 1'b1;
            S_SHIFT:    o_cmd.shift = 1'b1;
            S_MUL:      o_cmd.mul = 1'b1;
            S_CMP:      o_cmd.mac_init = 1'b1;
            S_MAC:      o_cmd.mac_step = 1'b1;
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_PUT:      o_cmd.put = !i_stat.out_full;
            default:    o_cmd = '0;
        endcase
    end

endmodule

[rtl/rgbc_dp.sv]
// ----------------------------------------------------------------------------
// rgbc_dp
// Datapath: line stores, 3x3 window, position counters, shared
// multiply-accumulate, restoring dividers and the output register.
// ----------------------------------------------------------------------------
module rgbc_dp #(
    parameter  int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
    parameter  int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rgbc_pkg::t_cmd    i_cmd,
    output rgbc_pkg::t_stat   o_stat,
    input  rgbc_pkg::t_in_req i_req,
    input  logic [WW-1:0]     i_w,
    input  logic [HW-1:0]     i_h,
    input  logic [23:0]       i_k_top,
    input  logic [23:0]       i_k_mid,
    input  logic [23:0]       i_k_bot,
    output rgbc_pkg::t_out_res o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready
);
    import rgbc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NW = ROW_W + WW + 1;

    logic [23:0] r_upper [MAX_WIDTH];
    logic [23:0] r_middle [MAX_WIDTH];
    logic [23:0] r_top_q, r_mid_q;
    logic [23:0] r_win [3][3];
    t_in_req     r_req;

    logic [CW-1:0]    r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row;
    logic [HW-1:0]    r_out_row;
    logic [NW-1:0]    r_n, r_o;

    logic [2:0] r_rv, r_cv;
    logic [1:0] r_dy, r_dx;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [SUM_W-1:0] r_neg, r_pos;
    logic [DVS_W-1:0] r_dvs;
    logic [Q_W-1:0]   r_q [3];
    logic [REM_W-1:0] r_rem [3];
    logic [4:0]       r_cnt;

    t_out_res r_res;
    logic     r_res_valid;

    logic        done;
    logic [23:0] pixv;
    logic        in_wrap;
    logic [23:0] krow;
    logic signed [7:0] k;
    logic        tap_on;
    logic [CW-1:0]    n_out_col;
    logic [HW-1:0]    n_out_row;
    logic [7:0]  res_ch [3];

    assign done = (r_in_row >= ROW_W'(i_h));
    assign pixv = done ? 24'd0 : {r_req.blue_in, r_req.green_in, r_req.red_in};
    assign in_wrap = ((WW + 1)'(r_in_col) + (WW + 1)'(1)) >= (WW + 1)'(i_w);

    always_comb begin
        unique case (r_dy)
            2'd0:    krow = i_k_top;
            2'd1:    krow = i_k_mid;
            default: krow = i_k_bot;
        endcase
        k      = coef(krow, r_dx);
        tap_on = r_rv[r_dy] & r_cv[r_dx];
    end

    always_comb begin
        if (((WW + 1)'(r_out_col) + (WW + 1)'(1)) >= (WW + 1)'(i_w)) begin
            n_out_col = '0;
            n_out_row = r_out_row + HW'(1);
        end else begin
            n_out_col = r_out_col + CW'(1);
            n_out_row = r_out_row;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (r_dvs == '0) begin
                res_ch[ch] = 8'd0;
            end else if (r_q[ch] > Q_W'(255)) begin
                res_ch[ch] = 8'd255;
            end else begin
                res_ch[ch] = r_q[ch][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_top_q <= r_upper[r_in_col];
        end
        if (i_cmd.shift) begin
            r_upper[r_in_col] <= r_mid_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_mid_q <= r_middle[r_in_col];
        end
        if (i_cmd.shift) begin
            r_middle[r_in_col] <= pixv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            for (int y = 0; y < 3; y++) begin
                for (int x = 0; x < 3; x++) begin
                    r_win[y][x] <= '0;
                end
            end
        end else begin
            if (i_cmd.start && (r_out_row >= i_h)) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end
            if (i_cmd.shift) begin
                for (int y = 0; y < 3; y++) begin
                    r_win[y][0] <= r_win[y][1];
                    r_win[y][1] <= r_win[y][2];
                end
                r_win[0][2] <= r_top_q;
                r_win[1][2] <= r_mid_q;
                r_win[2][2] <= pixv;
                if (in_wrap) begin
                    r_in_col <= '0;
                    if (r_in_row < ROW_SAT) r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            if (i_cmd.put) begin
                if (n_out_row >= i_h) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else begin
                    r_out_col <= n_out_col;
                    r_out_row <= n_out_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_req;
        end
        if (i_cmd.mul) begin
            r_n <= NW'(r_in_row) * NW'(i_w) + NW'(r_in_col);
            r_o <= NW'(r_out_row) * NW'(i_w) + NW'(r_out_col);
        end
        if (i_cmd.mac_init) begin
            r_rv[0] <= (r_out_row != '0);
            r_rv[1] <= (r_out_row < i_h);
            r_rv[2] <= ((HW + 1)'(r_out_row) + (HW + 1)'(1)) < (HW + 1)'(i_h);
            r_cv[0] <= (r_out_col != '0);
            r_cv[1] <= ((WW + 1)'(r_out_col) < (WW + 1)'(i_w));
            r_cv[2] <= ((WW + 1)'(r_out_col) + (WW + 1)'(1)) < (WW + 1)'(i_w);
            r_dy    <= 2'd0;
            r_dx    <= 2'd0;
            r_neg   <= '0;
            r_pos   <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                r_acc[ch] <= '0;
            end
        end
        if (i_cmd.mac_step) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (tap_on) begin
                    r_acc[ch] <= r_acc[ch] + ACC_W'(signed'({1'b0, r_win[r_dy][r_dx][8*ch +: 8]})
                                 * k);
                end
            end
            if (k < 0) r_neg <= r_neg + SUM_W'(k);
            if (k > 0) r_pos <= r_pos + SUM_W'(k);
            if (r_dx == 2'd2) begin
                r_dx <= 2'd0;
                r_dy <= r_dy + 2'd1;
            end else begin
                r_dx <= r_dx + 2'd1;
            end
        end
        if (i_cmd.div_init) begin
            r_dvs <= DVS_W'(r_pos - r_neg);
            r_cnt <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                logic signed [21:0] nx;
                logic signed [21:0] num;
                nx  = 22'(r_neg);
                num = 22'(r_acc[ch]) - ((nx <<< 8) - nx);
                r_q[ch]   <= (num < 0) ? '0 : num[Q_W-1:0];
                r_rem[ch] <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            for (int ch = 0; ch < 3; ch++) begin
                logic [REM_W:0] sh;
                sh = {r_rem[ch], r_q[ch][Q_W-1]};
                if (sh >= (REM_W + 1)'(r_dvs)) begin
                    r_rem[ch] <= REM_W'(sh - (REM_W + 1)'(r_dvs));
                    r_q[ch]   <= {r_q[ch][Q_W-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= sh[REM_W-1:0];
                    r_q[ch]   <= {r_q[ch][Q_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.put) begin
            r_res.red_out   <= res_ch[0];
            r_res.green_out <= res_ch[1];
            r_res.blue_out  <= res_ch[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_stat.skip     = (r_req.req_type == REQ_FLUSH) && !done;
    assign o_stat.emit     = (r_n >= r_o + NW'(i_w) + NW'(2));
    assign o_stat.mac_last = (r_dy == 2'd2) && (r_dx == 2'd2);
    assign o_stat.div_last = (r_cnt == DIV_LAST);
    assign o_stat.out_full = r_res_valid;

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

[rtl/rgb_3x3_convolution_normalized.sv]
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_normalized
// Streaming 3x3 RGB convolution with zero padding, normalised to 8 bits.
//
//   channel | valid / ready            | payload
//   in      | i_in_valid / o_in_ready  | i_in  (req_type, red/green/blue_in)
//   out     | o_out_valid / i_out_ready| o_out (red/green/blue_out)
//   cfg     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A request that produces a pixel runs the shared multiply-accumulate over
// the nine window taps, then the restoring divider for 19 quotient bits.
// A request with no result ends at the timing check, an ignored flush sooner.
// Synchronous active-low reset clears counters, window and sequencer.
// A result held in the output register stalls the next hand-off and input.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_normalized #(
    parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rgbc_pkg::t_in_req                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rgbc_pkg::t_out_res                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rgbc_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [23:0] r_k_top, r_k_mid, r_k_bot;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_k_top  <= RST_K_TOP;
            r_k_mid  <= RST_K_MID;
            r_k_bot  <= RST_K_BOT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                CFG_K_TOP:  r_k_top  <= i_cfg_data;
                CFG_K_MID:  r_k_mid  <= i_cfg_data;
                CFG_K_BOT:  r_k_bot  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = HW'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_height);
        end
    end

    rgbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rgbc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_in),
        .i_w         (eff_w),
        .i_h         (eff_h),
        .i_k_top     (r_k_top),
        .i_k_mid     (r_k_mid),
        .i_k_bot     (r_k_bot),
        .o_res       (o_out),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready)
    );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the normalised RGB 3x3 convolution against a behavioural predictor.
// A directed table with an identity kernel comes first, then edge-case frames
// and frames of random size, kernel and content, with random idling on both
// handshakes, an output hold-off that backs the block up, and ignored flushes.
// ----------------------------------------------------------------------------
module testbench;
    import rgbc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_req     i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_res    o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rgb_3x3_convolution_normalized dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    typedef struct {
        logic        req_type;
        logic [23:0] pix;
        bit          known;
        logic [23:0] known_pix;
    } t_row;

    // predictor state
    logic [10:0] pr_width;
    logic [12:0] pr_height;
    logic [23:0] pr_k_top, pr_k_mid, pr_k_bot;
    logic [23:0] line_upper [1024];
    logic [23:0] line_middle [1024];
    logic [23:0] win [3][3];
    int unsigned in_col, in_row, out_col, out_row;

    t_out_res    pixel_q[$];
    int          errors;
    int          pixels_sent;
    int          results_seen;
    int          hold_cnt;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int coef_at(input int dy, input int dx);
        logic [23:0] rg;
        logic signed [7:0] b;
        rg = (dy == 0) ? pr_k_top : (dy == 1) ? pr_k_mid : pr_k_bot;
        b = signed'(rg[8*dx +: 8]);
        return b;
    endfunction

    task automatic clear_counters();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic reset_predictor();
        pr_width = RST_WIDTH;
        pr_height = RST_HEIGHT;
        pr_k_top = RST_K_TOP;
        pr_k_mid = RST_K_MID;
        pr_k_bot = RST_K_BOT;
        foreach (line_upper[i]) begin
            line_upper[i] = '0;
            line_middle[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
        clear_counters();
    endtask

    task automatic filter_pixel(input t_in_req r, output bit got, output t_out_res res);
        int unsigned w, h, col;
        bit done;
        logic [23:0] pix, outv;
        longint n, o, acc, num, rr, cc, q;
        int neg, pos, k;
        got = 1'b0;
        res = '0;
        w = (pr_width < 1) ? 1 : (pr_width > 1024) ? 1024 : pr_width;
        h = (pr_height < 1) ? 1 : (pr_height > 4096) ? 4096 : pr_height;
        if (out_row >= h) clear_counters();
        done = in_row >= h;
        if (!done && r.req_type == REQ_FLUSH) return;
        pix = done ? 24'h0 : {r.red_in, r.green_in, r.blue_in};
        col = (in_col < 1024) ? in_col : 0;
        for (int dy = 0; dy < 3; dy++)
            for (int dx = 0; dx < 2; dx++)
                win[dy][dx] = win[dy][dx+1];
        win[0][2] = line_upper[col];
        win[1][2] = line_middle[col];
        win[2][2] = pix;
        line_upper[col] = line_middle[col];
        line_middle[col] = pix;
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < 32'h1000_0000) in_row++;
        end else begin
            in_col++;
        end
        n = longint'(in_row) * w + in_col;
        o = longint'(out_row) * w + out_col;
        if (n < o + w + 2) return;
        neg = 0;
        pos = 0;
        for (int dy = 0; dy < 3; dy++)
            for (int dx = 0; dx < 3; dx++) begin
                k = coef_at(dy, dx);
                if (k < 0) neg += k;
                if (k > 0) pos += k;
            end
        outv = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++) begin
                    rr = longint'(out_row) + dy - 1;
                    cc = longint'(out_col) + dx - 1;
                    if (rr < 0 || cc < 0 || rr >= h || cc >= w) continue;
                    acc += longint'(win[dy][dx][8*ch +: 8]) * coef_at(dy, dx);
                end
            if (pos != neg) begin
                num = acc - 255 * longint'(neg);
                if (num < 0) num = 0;
                q = num / (pos - neg);
                if (q > 255) q = 255;
                outv[8*ch +: 8] = q[7:0];
            end
        end
        if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        if (out_row >= h) clear_counters();
        res = outv;
        got = 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIDTH:  pr_width = data[10:0];
            CFG_HEIGHT: pr_height = data[12:0];
            CFG_K_TOP:  pr_k_top = data;
            CFG_K_MID:  pr_k_mid = data;
            CFG_K_BOT:  pr_k_bot = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_request(input logic rt, input logic [23:0] pix, input bit known,
                                input logic [23:0] known_pix);
        t_in_req r;
        bit got;
        t_out_res res;
        int gap;
        gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        r.req_type = rt;
        {r.red_in, r.green_in, r.blue_in} = pix;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in = r;
        do @(posedge i_clk); while (!o_in_ready);
        filter_pixel(r, got, res);
        if (got) pixel_q.insert(pixel_q.size(), known ? t_out_res'(known_pix) : res);
        if (rt == REQ_PIXEL) pixels_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_frame(input logic [23:0] wreg, input logic [23:0] hreg,
                             input logic [23:0] kt, input logic [23:0] km,
                             input logic [23:0] kb);
        int w, h;
        write_reg(CFG_WIDTH, wreg);
        write_reg(CFG_HEIGHT, hreg);
        write_reg(CFG_K_TOP, kt);
        write_reg(CFG_K_MID, km);
        write_reg(CFG_K_BOT, kb);
        w = (wreg[10:0] < 1) ? 1 : (wreg[10:0] > 1024) ? 1024 : wreg[10:0];
        h = (hreg[12:0] < 1) ? 1 : (hreg[12:0] > 4096) ? 4096 : hreg[12:0];
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < 4) send_request(REQ_FLUSH, 24'($urandom), 1'b0, 24'h0);
            send_request(REQ_PIXEL, 24'($urandom), 1'b0, 24'h0);
        end
        for (int i = 0; i <= w; i++)
            send_request(($urandom_range(99) < 25) ? REQ_PIXEL : REQ_FLUSH, 24'($urandom),
                         1'b0, 24'h0);
        if ($urandom_range(1)) send_request(REQ_FLUSH, 24'($urandom), 1'b0, 24'h0);
        settle();
    endtask

    function automatic logic [23:0] pick_kernel_row();
        case ($urandom_range(5))
            0: return 24'h000000;
            1: return 24'h808080;
            2: return 24'h7F7F7F;
            3: return 24'h000100;
            default: return 24'($urandom);
        endcase
    endfunction

    t_row dir_rows[12];

    initial begin
        dir_rows = '{
            '{REQ_FLUSH, 24'hABCDEF, 0, 24'h0},
            '{REQ_PIXEL, 24'h000000, 0, 24'h0},
            '{REQ_PIXEL, 24'hFFFFFF, 0, 24'h0},
            '{REQ_PIXEL, 24'h123456, 0, 24'h0},
            '{REQ_PIXEL, 24'hFF00FF, 0, 24'h0},
            '{REQ_PIXEL, 24'h00FF00, 1, 24'h000000},
            '{REQ_PIXEL, 24'hA5A5A5, 1, 24'hFFFFFF},
            '{REQ_FLUSH, 24'h000000, 1, 24'h123456},
            '{REQ_PIXEL, 24'h777777, 1, 24'hFF00FF},
            '{REQ_FLUSH, 24'h000000, 1, 24'h00FF00},
            '{REQ_FLUSH, 24'h000000, 1, 24'hA5A5A5},
            '{REQ_FLUSH, 24'h5A5A5A, 0, 24'h0}
        };
        errors = 0;
        pixels_sent = 0;
        results_seen = 0;
        hold_cnt = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        reset_predictor();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_WIDTH, 24'd3);
        write_reg(CFG_HEIGHT, 24'd2);
        foreach (dir_rows[i])
            send_request(dir_rows[i].req_type, dir_rows[i].pix, dir_rows[i].known,
                         dir_rows[i].known_pix);
        settle();

        run_frame(24'd0, 24'd0, 24'h000000, 24'h000000, 24'h000000);
        run_frame(24'd4, 24'd3, 24'h808080, 24'h808080, 24'h808080);
        run_frame(24'd5, 24'd4, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        run_frame(24'hFFF80C, 24'd1, 24'($urandom), 24'($urandom), 24'($urandom));
        run_frame(24'd1, 24'hFFE003, 24'h000000, 24'h000100, 24'h000000);

        for (int f = 0; pixels_sent < 900; f++) begin
            logic [23:0] wr, hr;
            calm = (f >= 3 && f < 8);
            wr = ($urandom_range(9) == 0) ? 24'($urandom_range(0, 40))
                                          : 24'($urandom_range(1, 12));
            hr = ($urandom_range(9) == 0) ? 24'($urandom_range(0, 10))
                                          : 24'($urandom_range(1, 6));
            run_frame(wr, hr, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
        end
        calm = 1'b0;

        if (errors == 0 && pixel_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_ready = 1'b0;
            hold_cnt--;
        end else begin
            i_out_ready = calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_out_res want;
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_out));
            end else begin
                want = pixel_q.pop_front();
                if (o_out.red_out !== want.red_out)
                    report_mismatch($sformatf("red %h, want %h", o_out.red_out, want.red_out));
                if (o_out.green_out !== want.green_out)
                    report_mismatch($sformatf("green %h, want %h", o_out.green_out,
                                              want.green_out));
                if (o_out.blue_out !== want.blue_out)
                    report_mismatch($sformatf("blue %h, want %h", o_out.blue_out,
                                              want.blue_out));
            end
            results_seen++;
            if (results_seen == 150) hold_cnt = 600;
        end
    end

endmodule

[sim.f]
rtl/rgbc_pkg.sv
rtl/rgbc_ctrl.sv
rtl/rgbc_dp.sv
rtl/rgb_3x3_convolution_normalized.sv
test/testbench.sv
